@@ rtl/handle_table_allocator_defines.svh @@
// assertion macros for the handle table allocator
// no dependencies; included by the top level only
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define HTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define HTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hta_pkg.sv @@
// shared types and codes of the handle table allocator
// no dependencies; used by hta_ctrl, hta_datapath and handle_table_allocator
package hta_pkg;

    // operation codes
    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_GET       = 3'd1;
    localparam logic [2:0] OP_FREE      = 3'd2;
    localparam logic [2:0] OP_DUP       = 3'd3;
    localparam logic [2:0] OP_CLOSE_ALL = 3'd4;
    localparam logic [2:0] OP_SET_STD   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_BAD_FD  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // dup target that asks for the lowest free slot
    localparam logic signed [7:0] TGT_AUTO = -8'sd1;

    // slots written by set_standard, held in flops
    localparam int STD_SLOTS = 3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [7:0]  slot_index;
        logic signed [7:0]  target_index;
        logic [31:0]        handle;
        logic [31:0]        handle_second;
        logic [31:0]        handle_third;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_result;
        logic [31:0] handle_out;
        logic [6:0]  occupied_count;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // take input beat and start the slot read
        logic exec;   // finish the operation and load the result register
    } t_cmd;

endpackage

@@ rtl/hta_ctrl.sv @@
// controller of the handle table allocator: accept, execute, result hand-off
// depends on hta_pkg
module hta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hta_pkg::t_cmd o_cmd
);
    import hta_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // input side is open whenever no item is in flight
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // commands
    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.exec) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/hta_datapath.sv @@
// datapath of the handle table allocator: slot memory, occupancy, count, result
// depends on hta_pkg; driven by hta_ctrl commands
module hta_datapath #(
    parameter int TABLE_SLOTS        = 64,
    parameter int HANDLE_BITS        = 32,
    parameter int FIRST_GENERAL_SLOT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hta_pkg::t_cmd i_cmd,
    input  hta_pkg::t_req i_req,
    output hta_pkg::t_rsp o_rsp
);
    import hta_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    // slot memory (slots 0..2 live in flops instead)
    logic [HANDLE_BITS-1:0] r_mem [TABLE_SLOTS];
    logic [HANDLE_BITS-1:0] r_std [STD_SLOTS];
    logic [HANDLE_BITS-1:0] r_rd_data;

    logic [TABLE_SLOTS-1:0] r_occ, n_occ;
    logic [CNT_W-1:0]       r_count, n_count;
    t_req                   r_req;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   r_free_ok, n_free_ok;
    t_rsp                   r_rsp;

    logic [IDX_W-1:0]       rd_addr;
    logic                   src_ok, src_live, tgt_ok;
    logic [IDX_W-1:0]       src_idx, tgt_idx;
    logic [HANDLE_BITS-1:0] h0, h1, h2, src_h;

    logic [1:0]             n_status;
    logic [5:0]             n_chosen;
    logic [HANDLE_BITS-1:0] n_hout;
    logic                   wr_en, clr_all, set_std;
    logic [IDX_W-1:0]       wr_idx;
    logic [HANDLE_BITS-1:0] wr_h;

    assign o_rsp = r_rsp;

    // read address from the incoming beat
    assign rd_addr = IDX_W'(i_req.slot_index[6:0]);

    // lowest free general slot, searched while the item is taken in
    always_comb begin
        n_free_idx = '0;
        n_free_ok  = 1'b0;
        for (int i = TABLE_SLOTS - 1; i >= FIRST_GENERAL_SLOT; i--) begin
            if (!r_occ[i]) begin
                n_free_idx = IDX_W'(i);
                n_free_ok  = 1'b1;
            end
        end
    end

    // input register, memory read and free-slot result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req;
            r_rd_data  <= r_mem[rd_addr];
            r_free_idx <= n_free_idx;
            r_free_ok  <= n_free_ok;
        end
    end

    // decode of the held item
    always_comb begin
        h0       = HANDLE_BITS'(r_req.handle);
        h1       = HANDLE_BITS'(r_req.handle_second);
        h2       = HANDLE_BITS'(r_req.handle_third);
        src_ok   = !r_req.slot_index[7]
                   && (32'(r_req.slot_index[6:0]) < TABLE_SLOTS);
        tgt_ok   = !r_req.target_index[7]
                   && (32'(r_req.target_index[6:0]) < TABLE_SLOTS);
        src_idx  = IDX_W'(r_req.slot_index[6:0]);
        tgt_idx  = IDX_W'(r_req.target_index[6:0]);
        src_live = src_ok && r_occ[src_idx];
        if (!src_live) begin
            src_h = '0;
        end else if (src_idx < IDX_W'(STD_SLOTS)) begin
            src_h = r_std[src_idx[1:0]];
        end else begin
            src_h = r_rd_data;
        end
    end

    // operation
    always_comb begin
        n_status = ST_OK;
        n_chosen = '0;
        n_hout   = '0;
        wr_en    = 1'b0;
        wr_idx   = src_idx;
        wr_h     = '0;
        clr_all  = 1'b0;
        set_std  = 1'b0;
        unique case (r_req.operation)
            OP_ALLOC: begin
                if (h0 == '0) begin
                    n_status = ST_BAD_ARG;
                end else if (!r_free_ok) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    wr_idx   = r_free_idx;
                    wr_h     = h0;
                    n_chosen = 6'(r_free_idx);
                end
            end
            OP_GET: begin
                if (!src_ok) begin
                    n_status = ST_BAD_FD;
                end else begin
                    n_hout = src_h;
                end
            end
            OP_FREE: begin
                if (!src_live) begin
                    n_status = ST_BAD_FD;
                end else begin
                    wr_en = 1'b1;
                end
            end
            OP_DUP: begin
                if (!src_live) begin
                    n_status = ST_BAD_FD;
                end else if (tgt_ok) begin
                    wr_en    = 1'b1;
                    wr_idx   = tgt_idx;
                    wr_h     = src_h;
                    n_chosen = 6'(tgt_idx);
                end else if (r_req.target_index == TGT_AUTO) begin
                    if (!r_free_ok) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_idx   = r_free_idx;
                        wr_h     = src_h;
                        n_chosen = 6'(r_free_idx);
                    end
                end else begin
                    n_status = ST_BAD_FD;
                end
            end
            OP_CLOSE_ALL: begin
                clr_all = 1'b1;
            end
            OP_SET_STD: begin
                set_std = 1'b1;
            end
            default: begin
                n_status = ST_BAD_ARG;
            end
        endcase
    end

    // next occupancy and count
    always_comb begin
        n_occ   = r_occ;
        n_count = r_count;
        if (clr_all) begin
            n_occ   = '0;
            n_count = '0;
        end else if (set_std) begin
            n_occ[0] = (h0 != '0);
            n_occ[1] = (h1 != '0);
            n_occ[2] = (h2 != '0);
            n_count  = r_count
                       - CNT_W'(r_occ[0]) - CNT_W'(r_occ[1]) - CNT_W'(r_occ[2])
                       + CNT_W'(h0 != '0) + CNT_W'(h1 != '0) + CNT_W'(h2 != '0);
        end else if (wr_en) begin
            n_occ[wr_idx] = (wr_h != '0);
            n_count       = r_count - CNT_W'(r_occ[wr_idx]) + CNT_W'(wr_h != '0);
        end
    end

    // occupancy bits and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_occ   <= n_occ;
            r_count <= n_count;
        end
    end

    // slot contents; free slots are masked by the occupancy bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (set_std) begin
                r_std[0] <= h0;
                r_std[1] <= h1;
                r_std[2] <= h2;
            end else if (wr_en) begin
                if (wr_idx < IDX_W'(STD_SLOTS)) begin
                    r_std[wr_idx[1:0]] <= wr_h;
                end else begin
                    r_mem[wr_idx] <= wr_h;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp.status         <= n_status;
            r_rsp.slot_result    <= n_chosen;
            r_rsp.handle_out     <= 32'(n_hout);
            r_rsp.occupied_count <= 7'(n_count);
        end
    end

endmodule

@@ rtl/handle_table_allocator.sv @@
// the input beat and the slot memory read are registered, then execution loads the result register
// a new item is taken only once the last has executed; slot memory read, then execute and write
// the lowest-free search runs over the occupancy vector during the read cycle
// reset clears occupancy bits and the count at once; no clearing pass is needed
// a result waiting at the output does not block the next input beat
module handle_table_allocator #(
    parameter int TABLE_SLOTS        = 64,
    parameter int HANDLE_BITS        = 32,
    parameter int FIRST_GENERAL_SLOT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hta_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hta_pkg::t_rsp o_out_rsp
);
    import hta_pkg::*;

    `include "handle_table_allocator_defines.svh"

    t_cmd cmd;

    // controller
    hta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath
    hta_datapath #(
        .TABLE_SLOTS        (TABLE_SLOTS),
        .HANDLE_BITS        (HANDLE_BITS),
        .FIRST_GENERAL_SLOT (FIRST_GENERAL_SLOT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

    // checks
    `HTA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, cmd.load, !o_in_ready, "accepted while busy")
    `HTA_ASSERT_NOW(a_exec_output_free, i_clk, i_rst_n, cmd.exec, !o_out_valid || i_out_ready, "result overwritten")
    `HTA_ASSERT_NEXT(a_result_after_exec, i_clk, i_rst_n, cmd.exec, o_out_valid, "result beat missing")
    `HTA_ASSERT_NOW(a_load_exec_apart, i_clk, i_rst_n, cmd.load, !cmd.exec, "load and execute together")

endmodule

@@ verif/handle_table_allocator_tb.sv @@
// self-checking bench for handle_table_allocator: directed table, then phased random traffic
// depends on hta_pkg and the handle_table_allocator rtl; every result beat is checked against
// a behavioural model of the slot table, or the directed table's own result for pinned rows
module handle_table_allocator_tb;
    import hta_pkg::*;

    localparam int TABLE_SLOTS        = 64;
    localparam int FIRST_GENERAL_SLOT = 3;
    localparam int N_PHASES           = 10;
    localparam int PHASE_ITEMS        = 103;
    localparam int QUIET_LIMIT        = 1000;
    localparam int DRAIN_CYCLES       = 8;

    // codes outside the defined operation set
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef enum int {IDLE_FULL, IDLE_NONE, IDLE_SHORT} t_idle;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    typedef struct {
        t_req req;
        bit   pinned;
        t_rsp rsp;
    } t_stim_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_req  i_in_req;
    logic  o_out_valid;
    logic  i_out_ready;
    t_rsp  o_out_rsp;

    // bench state
    logic [31:0] slot_model [TABLE_SLOTS];
    logic [6:0]  occupied_model;
    t_rsp        pending_rsp_q [$];
    t_stim_row   directed_rows [$];
    bit          pin_valid;
    t_rsp        pin_rsp;
    t_idle       idle_mode = IDLE_FULL;
    int          error_count  = 0;
    int          in_beats     = 0;
    int          out_beats    = 0;
    int          full_replies = 0;
    int          bad_fd_replies = 0;
    int          quiet_cycles = 0;

    handle_table_allocator #(
        .TABLE_SLOTS        (TABLE_SLOTS),
        .HANDLE_BITS        (32),
        .FIRST_GENERAL_SLOT (FIRST_GENERAL_SLOT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // slot table model
    function automatic bit slot_in_range(int d);
        return d >= 0 && d < TABLE_SLOTS;
    endfunction

    function automatic int model_lowest_free();
        for (int i = FIRST_GENERAL_SLOT; i < TABLE_SLOTS; i++)
            if (slot_model[i] == '0) return i;
        return -1;
    endfunction

    function automatic void model_write(int d, logic [31:0] h);
        if (slot_model[d] != '0) occupied_model--;
        if (h != '0) occupied_model++;
        slot_model[d] = h;
    endfunction

    function automatic t_rsp table_step(t_req req);
        t_rsp rsp;
        int   src;
        int   tgt;
        int   d;
        rsp = '0;
        src = int'($signed(req.slot_index));
        tgt = int'($signed(req.target_index));
        case (req.operation)
            OP_ALLOC: begin
                if (req.handle == '0) begin
                    rsp.status = ST_BAD_ARG;
                end else begin
                    d = model_lowest_free();
                    if (d < 0) begin
                        rsp.status = ST_FULL;
                    end else begin
                        model_write(d, req.handle);
                        rsp.slot_result = 6'(d);
                    end
                end
            end
            OP_GET: begin
                if (!slot_in_range(src)) rsp.status = ST_BAD_FD;
                else rsp.handle_out = slot_model[src];
            end
            OP_FREE: begin
                if (!slot_in_range(src) || slot_model[src] == '0) rsp.status = ST_BAD_FD;
                else model_write(src, '0);
            end
            OP_DUP: begin
                if (!slot_in_range(src) || slot_model[src] == '0) begin
                    rsp.status = ST_BAD_FD;
                end else if (slot_in_range(tgt)) begin
                    model_write(tgt, slot_model[src]);
                    rsp.slot_result = 6'(tgt);
                end else if (tgt == int'(TGT_AUTO)) begin
                    d = model_lowest_free();
                    if (d < 0) begin
                        rsp.status = ST_FULL;
                    end else begin
                        model_write(d, slot_model[src]);
                        rsp.slot_result = 6'(d);
                    end
                end else begin
                    rsp.status = ST_BAD_FD;
                end
            end
            OP_CLOSE_ALL: begin
                for (int i = 0; i < TABLE_SLOTS; i++) slot_model[i] = '0;
                occupied_model = '0;
            end
            OP_SET_STD: begin
                model_write(0, req.handle);
                model_write(1, req.handle_second);
                model_write(2, req.handle_third);
            end
            default: rsp.status = ST_BAD_ARG;
        endcase
        rsp.occupied_count = occupied_model;
        return rsp;
    endfunction

    // field-by-field compare of one result beat
    task automatic check_rsp(t_rsp want, t_rsp got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
        if (got.slot_result !== want.slot_result) begin
            $error("slot_result: expected %0d, got %0d", want.slot_result, got.slot_result);
            error_count++;
        end
        if (got.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out, got.handle_out);
            error_count++;
        end
        if (got.occupied_count !== want.occupied_count) begin
            $error("occupied_count: expected %0d, got %0d",
                   want.occupied_count, got.occupied_count);
            error_count++;
        end
    endtask

    // beat monitor: retire the result beat first, then model the input beat
    always @(posedge i_clk) begin : beat_monitor
        t_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_beats++;
                if (pending_rsp_q.size() == 0) begin
                    $error("result beat with nothing pending");
                    error_count++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    check_rsp(want, o_out_rsp);
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_beats++;
                want = table_step(i_in_req);
                if (pin_valid) want = pin_rsp;
                if (want.status == ST_FULL) full_replies++;
                if (want.status == ST_BAD_FD) bad_fd_replies++;
                pending_rsp_q.push_back(want);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no beat for %0d cycles", QUIET_LIMIT);
        $display("** handle_table_allocator: FAILED **");
        $finish;
    end

    // per-beat wait drawn by both sides
    function automatic int draw_wait();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_SHORT: return $urandom_range(0, 2);
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    // result side back-pressure
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // present one request beat and hold it until taken
    task automatic send_req(t_req req, bit pinned, t_rsp pinned_rsp);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_req   = req;
        pin_valid  = pinned;
        pin_rsp    = pinned_rsp;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic void add_row(logic [2:0] op, int src, int tgt, logic [31:0] h0,
                                    logic [31:0] h1, logic [31:0] h2, bit pinned,
                                    logic [1:0] st, int slot, logic [31:0] hout, int cnt);
        t_stim_row row;
        row.req.operation     = op;
        row.req.slot_index    = 8'(src);
        row.req.target_index  = 8'(tgt);
        row.req.handle        = h0;
        row.req.handle_second = h1;
        row.req.handle_third  = h2;
        row.pinned            = pinned;
        row.rsp               = t_rsp'{st, 6'(slot), hout, 7'(cnt)};
        directed_rows.push_back(row);
    endfunction

    // random request shaping
    function automatic logic [2:0] pick_op(t_mix mix);
        int roll;
        int cut [6];
        roll = $urandom_range(0, 99);
        // cumulative: alloc, dup, get, free, set_standard, close_all; the rest reserved codes
        case (mix)
            MIX_FILL:  cut = '{60, 80, 88, 91, 96, 96};
            MIX_DRAIN: cut = '{12, 27, 47, 92, 96, 98};
            default:   cut = '{25, 45, 65, 85, 93, 96};
        endcase
        if (roll < cut[0]) return OP_ALLOC;
        if (roll < cut[1]) return OP_DUP;
        if (roll < cut[2]) return OP_GET;
        if (roll < cut[3]) return OP_FREE;
        if (roll < cut[4]) return OP_SET_STD;
        if (roll < cut[5]) return OP_CLOSE_ALL;
        return ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
    endfunction

    // mostly an occupied slot, so free and dup get past the descriptor check
    function automatic logic signed [7:0] pick_source();
        int start;
        if ($urandom_range(0, 3) != 0 && occupied_model != '0) begin
            start = $urandom_range(0, TABLE_SLOTS - 1);
            for (int k = 0; k < TABLE_SLOTS; k++)
                if (slot_model[(start + k) % TABLE_SLOTS] != '0)
                    return 8'((start + k) % TABLE_SLOTS);
        end
        if ($urandom_range(0, 4) < 3) return 8'($urandom_range(0, TABLE_SLOTS - 1));
        return 8'($urandom);
    endfunction

    function automatic logic signed [7:0] pick_target(t_mix mix);
        int auto_pct;
        auto_pct = (mix == MIX_FILL) ? 60 : 30;
        if ($urandom_range(0, 99) < auto_pct) return TGT_AUTO;
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, TABLE_SLOTS - 1));
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_handle(int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct) return '0;
        if (roll < zero_pct + 4) return '1;
        return $urandom;
    endfunction

    function automatic t_req make_req(t_mix mix);
        t_req req;
        req.operation    = pick_op(mix);
        req.slot_index   = pick_source();
        req.target_index = pick_target(mix);
        if (req.operation == OP_SET_STD) begin
            req.handle        = pick_handle(30);
            req.handle_second = pick_handle(30);
            req.handle_third  = pick_handle(30);
        end else begin
            req.handle        = pick_handle(6);
            req.handle_second = $urandom;
            req.handle_third  = $urandom;
        end
        return req;
    endfunction

    // main sequence
    initial begin : stimulus
        t_stim_row row;
        t_mix      mix;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_ready = 1'b0;
        pin_valid   = 1'b0;
        pin_rsp     = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) slot_model[i] = '0;
        occupied_model = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: empty table, extremes, every operation, bad-argument and bad-descriptor codes
        add_row(OP_GET,       0,    0,   '0, '0, '0, 1, ST_OK,      0, '0, 0);
        add_row(OP_FREE,      5,    0,   '0, '0, '0, 1, ST_BAD_FD,  0, '0, 0);
        add_row(OP_ALLOC,     0,    0,   '0, '0, '0, 1, ST_BAD_ARG, 0, '0, 0);
        add_row(OP_ALLOC,     0,    0,   '1, '0, '0, 1, ST_OK,      3, '0, 1);
        add_row(OP_ALLOC,     0,    0,   32'd1, '0, '0, 1, ST_OK,   4, '0, 2);
        add_row(OP_GET,       3,    0,   '0, '0, '0, 1, ST_OK,      0, '1, 2);
        add_row(OP_GET,       -128, 0,   '0, '0, '0, 1, ST_BAD_FD,  0, '0, 2);
        add_row(OP_GET,       127,  0,   '0, '0, '0, 1, ST_BAD_FD,  0, '0, 2);
        add_row(OP_GET,       64,   0,   '0, '0, '0, 1, ST_BAD_FD,  0, '0, 2);
        add_row(OP_GET,       63,   0,   '0, '0, '0, 1, ST_OK,      0, '0, 2);
        add_row(OP_RSVD6,     3,    3,   '1, '1, '1, 1, ST_BAD_ARG, 0, '0, 2);
        add_row(OP_RSVD7,     3,    3,   '1, '1, '1, 1, ST_BAD_ARG, 0, '0, 2);
        add_row(OP_DUP,       3,    -1,  '0, '0, '0, 1, ST_OK,      5, '0, 3);
        add_row(OP_DUP,       3,    63,  '0, '0, '0, 1, ST_OK,      63, '0, 4);
        // dup onto itself leaves the slot and the count alone
        add_row(OP_DUP,       3,    3,   '0, '0, '0, 1, ST_OK,      3, '0, 4);
        add_row(OP_DUP,       10,   -1,  '0, '0, '0, 1, ST_BAD_FD,  0, '0, 4);
        add_row(OP_DUP,       3,    -128, '0, '0, '0, 1, ST_BAD_FD, 0, '0, 4);
        add_row(OP_DUP,       3,    64,  '0, '0, '0, 1, ST_BAD_FD,  0, '0, 4);
        add_row(OP_DUP,       -1,   5,   '0, '0, '0, 1, ST_BAD_FD,  0, '0, 4);
        add_row(OP_SET_STD,   0,    0,   '1, 32'd1, 32'h8000_0000, 1, ST_OK, 0, '0, 7);
        // null standard handles release their slots
        add_row(OP_SET_STD,   0,    0,   '0, '0, 32'd5, 1, ST_OK,  0, '0, 5);
        add_row(OP_DUP,       4,    1,   '0, '0, '0, 1, ST_OK,      1, '0, 6);
        add_row(OP_FREE,      2,    0,   '0, '0, '0, 1, ST_OK,      0, '0, 5);
        add_row(OP_FREE,      63,   0,   '0, '0, '0, 1, ST_OK,      0, '0, 4);
        add_row(OP_CLOSE_ALL, 0,    0,   '0, '0, '0, 1, ST_OK,      0, '0, 0);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_req(row.req, row.pinned, row.rsp);
        end

        // random phases: fill, drain and mixed traffic with varying idle behaviour
        for (int phase = 0; phase < N_PHASES; phase++) begin
            mix = t_mix'(phase % 3);
            if (phase == 1) idle_mode = IDLE_NONE;
            else idle_mode = t_idle'($urandom_range(0, 2));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_req(make_req(mix), 1'b0, '0);
        end
        i_in_valid = 1'b0;
        pin_valid  = 1'b0;

        // let outstanding results drain, then watch for strays
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests over %0d traffic phases, %0d results checked",
                 in_beats, N_PHASES, out_beats);
        $display("%0d table-full and %0d bad-descriptor replies among them",
                 full_replies, bad_fd_replies);
        if (error_count == 0)
            $display("** handle_table_allocator: PASSED **");
        else
            $display("** handle_table_allocator: FAILED **");
        $finish;
    end

endmodule
